// ===== rtl/core/dsha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsha_pkg
// Command and status codes and transfer field layout for the dense slot
// handle allocator.
// ----------------------------------------------------------------------------
package dsha_pkg;

    // command codes carried in the low bits of the input transfer
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_NO_SUCH = 2'd2;

    // field widths
    localparam int CMD_W    = 2;
    localparam int HIN_W    = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 10;
    localparam int LIVE_W   = 11;

    // transfer data widths, padded to whole bytes
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 56;

endpackage

// ===== rtl/core/dense_slot_handle_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_slot_handle_allocator
// Slot map with swap-remove: hands out handles for densely packed entries.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one command per transfer (add, delete by handle, look up).
//   m_* returns exactly one result per command: status, handle, dense slot,
//   a move order (copy record from move_from to move_to) and the live count.
//   Commands are processed one at a time. A full table or a never issued
//   handle is refused at once; else a lookup or delete reads the handle
//   map and is refused if the handle is dead. An add takes a fresh handle
//   or one from the freed-handle queue and writes both maps; a delete
//   swaps the top entry into the freed slot, queues the handle and, if an
//   entry moved, retires the deleted handle in a further step. s_tready
//   returns as the result enters the output register. The steps follow
//   the dependent reads of the synchronous maps and queue and their write-back.
//   A finished result sits in the output register; the next command is
//   taken meanwhile, and only its result write waits while m_tready is low.
//   After reset all handles are dead and the block is ready at once: map
//   entries are judged against the fresh-handle counter, so no clearing
//   pass over the memories is run.
// ----------------------------------------------------------------------------
module dense_slot_handle_allocator
    import dsha_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    // command, handle_in
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    // status, handle_out, dense_index, move_valid, move_from, move_to,
    // live_count
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int HW = HIN_W + 1;
    localparam int SW = CW + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_WAIT,
        ST_ADD_WR,
        ST_LOOK,
        ST_DEL_TOP,
        ST_DEL_CLR,
        ST_RESP
    } state_t;

    // memories
    logic [IW:0]   h2s_mem  [MAX_ENTRIES];
    logic [IW-1:0] s2h_mem  [MAX_ENTRIES];
    logic [IW-1:0] fifo_mem [MAX_ENTRIES];

    logic [IW:0]   h2s_rd_reg;
    logic [IW-1:0] s2h_rd_reg;
    logic [IW-1:0] fifo_rd_reg;

    logic          h2s_we;
    logic [IW-1:0] h2s_waddr;
    logic [IW:0]   h2s_wdata;
    logic [IW-1:0] h2s_raddr;
    logic          s2h_we;
    logic [IW-1:0] s2h_waddr;
    logic [IW-1:0] s2h_wdata;
    logic          fifo_we;

    // control state
    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] fresh_reg, fresh_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic          m_tvalid_reg, m_tvalid_next;

    // payload
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [IW-1:0]       hin_reg, hin_next;
    logic [IW-1:0]       h_reg, h_next;
    logic [IW-1:0]       slot_reg, slot_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [IW-1:0]       res_handle_reg, res_handle_next;
    logic [IW-1:0]       res_index_reg, res_index_next;
    logic                res_move_reg, res_move_next;
    logic [IW-1:0]       res_from_reg, res_from_next;
    logic [IW-1:0]       res_to_reg, res_to_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [CMD_W-1:0] s_cmd;
    logic [HIN_W-1:0] s_hin;
    logic             out_free;
    logic [IW-1:0]    top;
    logic             moved;

    assign s_cmd    = s_tdata[CMD_W-1:0];
    assign s_hin    = s_tdata[CMD_W+HIN_W-1:CMD_W];
    assign out_free = !m_tvalid_reg || m_tready;
    assign top      = IW'(count_reg - CW'(1));
    assign moved    = (slot_reg != top);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // next pointer with wrap at the queue depth
    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
        logic [IW-1:0] r;
        if (p == IW'(MAX_ENTRIES - 1)) begin
            r = '0;
        end else begin
            r = p + IW'(1);
        end
        return r;
    endfunction

    // handle map: live bit over slot, read at the incoming handle
    assign h2s_raddr = IW'(s_hin);

    always_ff @(posedge aclk) begin
        if (h2s_we) begin
            h2s_mem[h2s_waddr] <= h2s_wdata;
        end
        h2s_rd_reg <= h2s_mem[h2s_raddr];
    end

    // slot map, read at the top slot
    always_ff @(posedge aclk) begin
        if (s2h_we) begin
            s2h_mem[s2h_waddr] <= s2h_wdata;
        end
        s2h_rd_reg <= s2h_mem[top];
    end

    // freed-handle queue, read at its head
    always_ff @(posedge aclk) begin
        if (fifo_we) begin
            fifo_mem[tail_reg] <= hin_reg;
        end
        fifo_rd_reg <= fifo_mem[head_reg];
    end

    // command sequencer
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        fresh_next      = fresh_reg;
        fill_next       = fill_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        m_tvalid_next   = m_tvalid_reg;
        cmd_next        = cmd_reg;
        hin_next        = hin_reg;
        h_next          = h_reg;
        slot_next       = slot_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        res_index_next  = res_index_reg;
        res_move_next   = res_move_reg;
        res_from_next   = res_from_reg;
        res_to_next     = res_to_reg;
        m_tdata_next    = m_tdata_reg;
        h2s_we          = 1'b0;
        h2s_waddr       = hin_reg;
        h2s_wdata       = '0;
        s2h_we          = 1'b0;
        s2h_waddr       = slot_reg;
        s2h_wdata       = s2h_rd_reg;
        fifo_we         = 1'b0;

        // output register drains independently
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next        = s_cmd;
                    hin_next        = IW'(s_hin);
                    res_status_next = STATUS_OK;
                    res_handle_next = '0;
                    res_index_next  = '0;
                    res_move_next   = 1'b0;
                    res_from_next   = '0;
                    res_to_next     = '0;
                    if (s_cmd == CMD_ADD) begin
                        if (count_reg == CW'(MAX_ENTRIES)) begin
                            res_status_next = STATUS_FULL;
                            state_next      = ST_RESP;
                        end else if (fill_reg == '0) begin
                            h_next     = IW'(fresh_reg);
                            fresh_next = fresh_reg + CW'(1);
                            state_next = ST_ADD_WR;
                        end else begin
                            state_next = ST_ADD_WAIT;
                        end
                    end else if (s_cmd == CMD_UNUSED || HW'(s_hin) >= HW'(fresh_reg)) begin
                        res_status_next = STATUS_NO_SUCH;
                        state_next      = ST_RESP;
                    end else begin
                        state_next = ST_LOOK;
                    end
                end
            end

            // recycled handle arrives from the queue
            ST_ADD_WAIT: begin
                h_next     = fifo_rd_reg;
                head_next  = wrap_inc(head_reg);
                fill_next  = fill_reg - CW'(1);
                state_next = ST_ADD_WR;
            end

            // place the new entry at the next dense slot
            ST_ADD_WR: begin
                h2s_we          = 1'b1;
                h2s_waddr       = h_reg;
                h2s_wdata       = {1'b1, IW'(count_reg)};
                s2h_we          = 1'b1;
                s2h_waddr       = IW'(count_reg);
                s2h_wdata       = h_reg;
                count_next      = count_reg + CW'(1);
                res_handle_next = h_reg;
                res_index_next  = IW'(count_reg);
                state_next      = ST_RESP;
            end

            // handle map entry is in; top slot read goes out
            ST_LOOK: begin
                slot_next = h2s_rd_reg[IW-1:0];
                if (!h2s_rd_reg[IW]) begin
                    res_status_next = STATUS_NO_SUCH;
                    state_next      = ST_RESP;
                end else if (cmd_reg == CMD_LOOKUP) begin
                    res_handle_next = hin_reg;
                    res_index_next  = h2s_rd_reg[IW-1:0];
                    state_next      = ST_RESP;
                end else begin
                    state_next = ST_DEL_TOP;
                end
            end

            // swap the top entry into the freed slot and queue the handle
            ST_DEL_TOP: begin
                h2s_we    = 1'b1;
                s2h_we    = 1'b1;
                s2h_waddr = slot_reg;
                s2h_wdata = s2h_rd_reg;
                fifo_we   = 1'b1;
                tail_next = wrap_inc(tail_reg);
                fill_next = fill_reg + CW'(1);
                count_next = count_reg - CW'(1);
                if (moved) begin
                    h2s_waddr     = s2h_rd_reg;
                    h2s_wdata     = {1'b1, slot_reg};
                    res_move_next = 1'b1;
                    res_from_next = top;
                    res_to_next   = slot_reg;
                    state_next    = ST_DEL_CLR;
                end else begin
                    h2s_waddr  = hin_reg;
                    h2s_wdata  = '0;
                    state_next = ST_RESP;
                end
            end

            // retire the deleted handle
            ST_DEL_CLR: begin
                h2s_we     = 1'b1;
                h2s_waddr  = hin_reg;
                h2s_wdata  = '0;
                state_next = ST_RESP;
            end

            // load the output register once it is free
            ST_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[1:0]   = res_status_reg;
                    m_tdata_next[11:2]  = SLOT_W'(res_handle_reg);
                    m_tdata_next[21:12] = SLOT_W'(res_index_reg);
                    m_tdata_next[22]    = res_move_reg;
                    m_tdata_next[32:23] = SLOT_W'(res_from_reg);
                    m_tdata_next[42:33] = SLOT_W'(res_to_reg);
                    m_tdata_next[53:43] = LIVE_W'(count_reg);
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            fresh_reg    <= '0;
            fill_reg     <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            fresh_reg    <= fresh_next;
            fill_reg     <= fill_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cmd_reg        <= cmd_next;
        hin_reg        <= hin_next;
        h_reg          <= h_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        res_index_reg  <= res_index_next;
        res_move_reg   <= res_move_next;
        res_from_reg   <= res_from_next;
        res_to_reg     <= res_to_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // every handle ever issued is either live or waiting in the queue,
    // except while an add holds its handle before the live count steps up
    a_handle_balance: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_ADD_WR |-> SW'(fill_reg) + SW'(count_reg) == SW'(fresh_reg))
        else $error("live and freed handles do not add up to issued handles");

    // fresh handles never run past the capacity
    a_fresh_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        SW'(fresh_reg) <= SW'(MAX_ENTRIES))
        else $error("fresh handle counter beyond capacity");

    // an add only commits when a slot is free
    a_add_room: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ADD_WR |-> SW'(count_reg) < SW'(MAX_ENTRIES))
        else $error("add committed to a full table");

    // a reported move never targets its own source slot
    a_move_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RESP && res_move_reg |-> res_from_reg != res_to_reg)
        else $error("self-move reported");

    // a delete reaching the swap step always has a live entry to take
    a_delete_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DEL_TOP |-> count_reg != '0)
        else $error("delete with no live entries");

endmodule

// ===== sim/dense_slot_handle_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_slot_handle_allocator_tb
// Self-checking bench for the slot map allocator. A short table of commands
// covers the corner cases, then random add, delete and look-up traffic builds
// the table up to several hundred entries and thins it out again. Every
// result transfer is compared field by field with a hand-written directed
// result or with a behavioural model of both maps and the freed-handle queue.
// ----------------------------------------------------------------------------
module dense_slot_handle_allocator_tb;
    import dsha_pkg::*;

    localparam int CAPACITY  = 1024;
    localparam bit TYPED     = 1'b1;
    localparam bit PREDICTED = 1'b0;

    // result fields, lowest bits last
    typedef struct packed {
        logic [LIVE_W-1:0]   live_count;
        logic [SLOT_W-1:0]   move_to;
        logic [SLOT_W-1:0]   move_from;
        logic                move_valid;
        logic [SLOT_W-1:0]   dense_index;
        logic [SLOT_W-1:0]   handle_out;
        logic [STATUS_W-1:0] status;
    } alloc_result_t;

    // one directed command, with its result where it is written out by hand
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [HIN_W-1:0]    hin;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   handle_out;
        logic [SLOT_W-1:0]   dense_index;
        logic                move_valid;
        logic [SLOT_W-1:0]   move_from;
        logic [SLOT_W-1:0]   move_to;
        logic [LIVE_W-1:0]   live_count;
    } cmd_row_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // model of the allocator state
    logic [SLOT_W-1:0] slot_of_handle [CAPACITY];
    logic              handle_is_live [CAPACITY];
    logic [SLOT_W-1:0] handle_of_slot [CAPACITY];
    logic [SLOT_W-1:0] recycled_handles [$];
    int                live_entries = 0;
    int                fresh_handle = 0;

    alloc_result_t pending_results [$];
    cmd_row_t      directed_rows [0:24];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int error_count        = 0;
    int n_add = 0, n_full = 0, n_delete = 0, n_move = 0;
    int n_lookup = 0, n_unknown = 0, n_checked = 0;

    dense_slot_handle_allocator #(
        .MAX_ENTRIES(CAPACITY)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // 125 MHz clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // run time limit
    initial begin
        #(5_000_000);
        $display("dense_slot_handle_allocator test failed");
        $finish;
    end

    // works out the result of one command and updates the model state
    function automatic alloc_result_t predict_alloc(input logic [CMD_W-1:0] cmd,
                                                    input logic [HIN_W-1:0] hin);
        alloc_result_t     r;
        logic [SLOT_W-1:0] h;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] top;
        logic [SLOT_W-1:0] top_h;
        r = '0;
        h = hin[SLOT_W-1:0];
        if (cmd == CMD_ADD) begin
            n_add++;
            if (live_entries >= CAPACITY) begin
                r.status = STATUS_FULL;
                n_full++;
            end else begin
                // recycled handles first, fresh ones only when none are queued
                if (recycled_handles.size() == 0) begin
                    h = fresh_handle[SLOT_W-1:0];
                    fresh_handle++;
                end else begin
                    h = recycled_handles.pop_front();
                end
                slot = live_entries[SLOT_W-1:0];
                slot_of_handle[h] = slot;
                handle_is_live[h] = 1'b1;
                handle_of_slot[slot] = h;
                live_entries++;
                r.handle_out  = h;
                r.dense_index = slot;
            end
        end else if (cmd == CMD_UNUSED || hin >= CAPACITY || !handle_is_live[h]) begin
            if (cmd == CMD_DELETE) n_delete++;
            else n_lookup++;
            r.status = STATUS_NO_SUCH;
            n_unknown++;
        end else if (cmd == CMD_LOOKUP) begin
            n_lookup++;
            r.handle_out  = h;
            r.dense_index = slot_of_handle[h];
        end else begin
            // swap-remove: top entry fills the freed slot
            n_delete++;
            slot  = slot_of_handle[h];
            top   = SLOT_W'(live_entries - 1);
            top_h = handle_of_slot[top];
            slot_of_handle[top_h] = slot;
            handle_of_slot[slot]  = top_h;
            handle_is_live[h]     = 1'b0;
            recycled_handles.push_back(h);
            live_entries--;
            if (slot != top) begin
                n_move++;
                r.move_valid = 1'b1;
                r.move_from  = top;
                r.move_to    = slot;
            end
        end
        r.live_count = live_entries[LIVE_W-1:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // offers one command, waits for its transfer and queues the expected result
    task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [HIN_W-1:0] hin,
                                 input logic typed, input alloc_result_t typed_result);
        alloc_result_t predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - CMD_W - HIN_W){1'b0}}, hin, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = predict_alloc(cmd, hin);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    // random traffic; fill_up runs on until six more adds are refused as full, up to 2 * n_items
    task automatic run_random_phase(input int n_items, input int add_pct, input int del_pct,
                                    input int idle_pct, input int stall_pct,
                                    input bit fill_up);
        int               i;
        int               pick;
        int               full_mark;
        logic [CMD_W-1:0] cmd;
        logic [HIN_W-1:0] hin;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        full_mark          = n_full;
        i                  = 0;
        while (i < n_items || (fill_up && n_full < full_mark + 6 && i < 2 * n_items)) begin
            pick = $urandom_range(99);
            if (pick < add_pct) cmd = CMD_ADD;
            else if (pick < add_pct + del_pct) cmd = CMD_DELETE;
            else if (pick < 97) cmd = CMD_LOOKUP;
            else cmd = CMD_UNUSED;
            // mostly live handles, some dead ones and some out of range
            pick = $urandom_range(9);
            if (pick < 7 && live_entries > 0)
                hin = {6'd0, handle_of_slot[$urandom_range(live_entries - 1)]};
            else if (pick < 9)
                hin = HIN_W'($urandom_range(CAPACITY - 1));
            else
                hin = HIN_W'($urandom_range(65535));
            issue_command(cmd, hin, PREDICTED, '0);
            i++;
        end
    endtask

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // result checking
    always @(posedge aclk) begin : result_check
        alloc_result_t got;
        alloc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(alloc_result_t)-1:0];
            if (pending_results.size() == 0) begin
                $error("result transfer with no command outstanding: %h", got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                check_field("status", want.status, got.status);
                check_field("handle_out", want.handle_out, got.handle_out);
                check_field("dense_index", want.dense_index, got.dense_index);
                check_field("move_valid", want.move_valid, got.move_valid);
                check_field("move_from", want.move_from, got.move_from);
                check_field("move_to", want.move_to, got.move_to);
                check_field("live_count", want.live_count, got.live_count);
            end
        end
    end

    // stimulus
    initial begin
        alloc_result_t row_result;
        for (int i = 0; i < CAPACITY; i++) handle_is_live[i] = 1'b0;

        // cmd, handle, typed, status, handle_out, dense_index, move_valid,
        // move_from, move_to, live_count
        directed_rows = '{
            '{CMD_LOOKUP, 16'h0000, TYPED,     STATUS_NO_SUCH, 0, 0, 0, 0, 0, 0},
            '{CMD_DELETE, 16'h0000, TYPED,     STATUS_NO_SUCH, 0, 0, 0, 0, 0, 0},
            '{CMD_LOOKUP, 16'hFFFF, TYPED,     STATUS_NO_SUCH, 0, 0, 0, 0, 0, 0},
            '{CMD_DELETE, 16'd1024, TYPED,     STATUS_NO_SUCH, 0, 0, 0, 0, 0, 0},
            '{CMD_UNUSED, 16'h0000, TYPED,     STATUS_NO_SUCH, 0, 0, 0, 0, 0, 0},
            '{CMD_ADD,    16'hFFFF, TYPED,     STATUS_OK,      0, 0, 0, 0, 0, 1},
            '{CMD_ADD,    16'h0000, TYPED,     STATUS_OK,      1, 1, 0, 0, 0, 2},
            '{CMD_ADD,    16'h1234, TYPED,     STATUS_OK,      2, 2, 0, 0, 0, 3},
            '{CMD_ADD,    16'h0000, TYPED,     STATUS_OK,      3, 3, 0, 0, 0, 4},
            // unused command on a live handle still fails
            '{CMD_UNUSED, 16'h0001, TYPED,     STATUS_NO_SUCH, 0, 0, 0, 0, 0, 4},
            '{CMD_LOOKUP, 16'h0001, TYPED,     STATUS_OK,      1, 1, 0, 0, 0, 4},
            // top entry removed, nothing to relocate
            '{CMD_DELETE, 16'h0003, TYPED,     STATUS_OK,      0, 0, 0, 0, 0, 3},
            // slot 0 freed, top slot 2 moves down
            '{CMD_DELETE, 16'h0000, TYPED,     STATUS_OK,      0, 0, 1, 2, 0, 2},
            '{CMD_LOOKUP, 16'h0002, PREDICTED, STATUS_OK,      0, 0, 0, 0, 0, 0},
            '{CMD_DELETE, 16'h0000, TYPED,     STATUS_NO_SUCH, 0, 0, 0, 0, 0, 2},
            // upper bits set, low bits alias a live handle
            '{CMD_LOOKUP, 16'h0402, TYPED,     STATUS_NO_SUCH, 0, 0, 0, 0, 0, 2},
            '{CMD_ADD,    16'h0000, PREDICTED, STATUS_OK,      0, 0, 0, 0, 0, 0},
            '{CMD_ADD,    16'h0000, PREDICTED, STATUS_OK,      0, 0, 0, 0, 0, 0},
            '{CMD_DELETE, 16'h0001, PREDICTED, STATUS_OK,      0, 0, 0, 0, 0, 0},
            '{CMD_LOOKUP, 16'h0003, PREDICTED, STATUS_OK,      0, 0, 0, 0, 0, 0},
            '{CMD_DELETE, 16'h0002, PREDICTED, STATUS_OK,      0, 0, 0, 0, 0, 0},
            '{CMD_DELETE, 16'h0003, PREDICTED, STATUS_OK,      0, 0, 0, 0, 0, 0},
            // last live entry removed
            '{CMD_DELETE, 16'h0000, PREDICTED, STATUS_OK,      0, 0, 0, 0, 0, 0},
            '{CMD_LOOKUP, 16'h03FF, TYPED,     STATUS_NO_SUCH, 0, 0, 0, 0, 0, 0},
            '{CMD_ADD,    16'h0000, PREDICTED, STATUS_OK,      0, 0, 0, 0, 0, 0}
        };

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, no idling
        foreach (directed_rows[r]) begin
            row_result = {directed_rows[r].live_count, directed_rows[r].move_to,
                          directed_rows[r].move_from, directed_rows[r].move_valid,
                          directed_rows[r].dense_index, directed_rows[r].handle_out,
                          directed_rows[r].status};
            issue_command(directed_rows[r].cmd, directed_rows[r].hin,
                          directed_rows[r].typed, row_result);
        end

        // hold off until every result is back
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);

        // mixed traffic, then build up, thin out, and mixed again
        run_random_phase(150, 45, 30, 0, 0, 1'b0);
        run_random_phase(350, 88, 6, 74, 0, 1'b0);
        run_random_phase(200, 10, 75, 0, 74, 1'b0);
        run_random_phase(125, 40, 35, 8, 8, 1'b0);

        // drain and let the pipeline settle
        s_tvalid <= 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d adds (%0d refused as full), %0d deletes (%0d relocating)",
                 n_add, n_full, n_delete, n_move);
        $display("and %0d lookups; %0d unknown-handle results, %0d results checked",
                 n_lookup, n_unknown, n_checked);
        if (error_count == 0) begin
            $display("dense_slot_handle_allocator test passed");
        end else begin
            $display("dense_slot_handle_allocator test failed");
        end
        $finish;
    end

endmodule
